@@ hdl/dtv_pkg.sv @@
// ----------------------------------------------------------------------------
// Date text validator package
// Shared types, status codes and calendar helpers for the dd/mm/yyyy checker.
// ----------------------------------------------------------------------------
package dtv_pkg;

   localparam int CharW   = 8;
   localparam int StatusW = 3;
   localparam int DayW    = 5;
   localparam int MonthW  = 4;
   localparam int YearW   = 14;
   localparam int PosW    = 4;
   localparam int AccW    = 7;   // two decimal digits, 0..99
   localparam int DigitW  = 4;

   localparam logic [PosW-1:0]  TextLen    = PosW'(10);
   localparam logic [PosW-1:0]  PosSat     = PosW'(11);
   localparam logic [PosW-1:0]  PosSep1    = PosW'(2);
   localparam logic [PosW-1:0]  PosSep2    = PosW'(5);
   localparam logic [PosW-1:0]  PosYear    = PosW'(6);
   localparam logic [PosW-1:0]  PosYearLo  = PosW'(8);
   localparam logic [CharW-1:0] CharSlash  = 8'h2F;
   localparam logic [CharW-1:0] CharZero   = 8'h30;
   localparam logic [CharW-1:0] CharNine   = 8'h39;
   localparam logic [MonthW-1:0] MonthFeb  = MonthW'(2);

   typedef enum logic [StatusW-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_FMT   = 3'd1,
      STATUS_NON_DIGIT = 3'd2,
      STATUS_BAD_MONTH = 3'd3,
      STATUS_BAD_DAY   = 3'd4
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [DayW-1:0]    day;
      logic [MonthW-1:0]  month;
      logic [YearW-1:0]   year;
   } result_type;

   // Length of a month 1..12; February follows the leap flag.
   function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                  input logic leap);
      logic [DayW-1:0] days;
      begin
         unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = DayW'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    days = DayW'(30);
            MonthFeb:                                   days = leap ? DayW'(29) : DayW'(28);
            default:                                    days = DayW'(0);
         endcase
         return days;
      end
   endfunction

endpackage

@@ hdl/date_text_validator.sv @@
// A result beat is registered: a final character's beat passes the input register,
// then the result register, which it enters once the result slot can take it.
// Throughput: one character per cycle, but a final character waits while the result
// register is full and stalled; the parser's state registers take one character per step.
// Reset: synchronous, active high; clears the input and output stages and all
// parse state, so the next character starts a new text.
// ----------------------------------------------------------------------------
// Date text validator
// Checks a dd/mm/yyyy text streamed one character per beat and gives one
// status beat on the final character, with the parsed date when the date is valid.
// ----------------------------------------------------------------------------
module date_text_validator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dtv_pkg::CharW-1:0]      req_char_code,
   input  logic                           req_last_char,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dtv_pkg::StatusW-1:0]    rsp_status,
   output logic [dtv_pkg::DayW-1:0]       rsp_day,
   output logic [dtv_pkg::MonthW-1:0]     rsp_month,
   output logic [dtv_pkg::YearW-1:0]      rsp_year
);

   logic                          in_valid_ff, in_valid_in;
   logic [dtv_pkg::CharW-1:0]     in_char_ff;
   logic                          in_last_ff;
   logic                          out_valid_ff, out_valid_in;
   dtv_pkg::result_type           out_ff;
   dtv_pkg::result_type           parsed;
   logic                          req_take;
   logic                          out_free;
   logic                          step;

   // A held character moves on unless it is a final one and the result slot is full and stalled.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   dtv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .result    (parsed)
   );

   always_comb begin
      if (req_take)  in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
      else           in_valid_in = in_valid_ff;
      if (out_free)  out_valid_in = step && in_last_ff;
      else           out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
      if (step && in_last_ff) begin
         out_ff <= parsed;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_day    = out_ff.day;
   assign rsp_month  = out_ff.month;
   assign rsp_year   = out_ff.year;

endmodule

@@ hdl/dtv_parser.sv @@
// ----------------------------------------------------------------------------
// Date text parser
// Holds the per-text state, folds in one character per step and produces the
// checked result on the final character.
// ----------------------------------------------------------------------------
module dtv_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [dtv_pkg::CharW-1:0]   char_code,
   input  logic                        last_char,
   output dtv_pkg::result_type         result
);

   logic [dtv_pkg::PosW-1:0]   pos_ff,     pos_in;
   logic [dtv_pkg::AccW-1:0]   day_ff,     day_in;
   logic [dtv_pkg::AccW-1:0]   month_ff,   month_in;
   logic [dtv_pkg::YearW-1:0]  year_ff,    year_in;
   logic [dtv_pkg::AccW-1:0]   yr_hi_ff,   yr_hi_in;
   logic [dtv_pkg::AccW-1:0]   yr_lo_ff,   yr_lo_in;
   logic                       fmt_err_ff, fmt_err_in;
   logic                       dig_err_ff, dig_err_in;

   logic [dtv_pkg::PosW-1:0]   pos_next;
   logic [dtv_pkg::AccW-1:0]   day_next, month_next, yr_hi_next, yr_lo_next;
   logic [dtv_pkg::YearW-1:0]  year_next;
   logic                       fmt_err_next, dig_err_next;
   logic                       is_digit;
   logic [dtv_pkg::DigitW-1:0] digit;
   logic [dtv_pkg::CharW-1:0]  char_off;
   logic                       leap;
   logic [dtv_pkg::DayW-1:0]   days_max;
   logic [dtv_pkg::AccW-1:0]   month_len;

   // Two-digit accumulate: acc * 10 + digit, kept to the accumulator width.
   function automatic logic [dtv_pkg::AccW-1:0] acc2(input logic [dtv_pkg::AccW-1:0] acc,
                                                    input logic [dtv_pkg::DigitW-1:0] v);
      logic [dtv_pkg::AccW+3:0] sum;
      begin
         sum = {4'b0, acc} * (dtv_pkg::AccW+4)'(10) + {{dtv_pkg::AccW{1'b0}}, v};
         return sum[dtv_pkg::AccW-1:0];
      end
   endfunction

   assign char_off = char_code - dtv_pkg::CharZero;
   assign digit    = char_off[dtv_pkg::DigitW-1:0];
   assign is_digit = (char_code >= dtv_pkg::CharZero) && (char_code <= dtv_pkg::CharNine);

   always_comb begin
      logic [dtv_pkg::YearW+3:0] year_sum;
      year_sum     = {4'b0, year_ff} * (dtv_pkg::YearW+4)'(10)
                   + {{dtv_pkg::YearW{1'b0}}, digit};
      day_next     = day_ff;
      month_next   = month_ff;
      year_next    = year_ff;
      yr_hi_next   = yr_hi_ff;
      yr_lo_next   = yr_lo_ff;
      fmt_err_next = fmt_err_ff;
      dig_err_next = dig_err_ff;
      if (pos_ff == dtv_pkg::PosSep1 || pos_ff == dtv_pkg::PosSep2) begin
         if (char_code != dtv_pkg::CharSlash) fmt_err_next = 1'b1;
      end else if (pos_ff < dtv_pkg::TextLen) begin
         if (!is_digit) begin
            dig_err_next = 1'b1;
         end else if (pos_ff < dtv_pkg::PosSep1) begin
            day_next = acc2(day_ff, digit);
         end else if (pos_ff < dtv_pkg::PosSep2) begin
            month_next = acc2(month_ff, digit);
         end else begin
            year_next = year_sum[dtv_pkg::YearW-1:0];
            // The year is also kept as two digit pairs for the leap test.
            if (pos_ff < dtv_pkg::PosYearLo) yr_hi_next = acc2(yr_hi_ff, digit);
            else                             yr_lo_next = acc2(yr_lo_ff, digit);
         end
      end else begin
         fmt_err_next = 1'b1;
      end
      pos_next = (pos_ff < dtv_pkg::PosSat) ? pos_ff + dtv_pkg::PosW'(1) : pos_ff;
   end

   // Divisibility by 4 of a two-digit pair is its low two bits. A year ending
   // in 00 is a leap year only when the century pair divides by 4.
   assign leap = (yr_lo_next != '0) ? (yr_lo_next[1:0] == 2'b00)
                                    : (yr_hi_next[1:0] == 2'b00);
   assign days_max  = dtv_pkg::month_days(month_next[dtv_pkg::MonthW-1:0], leap);
   assign month_len = {{(dtv_pkg::AccW-dtv_pkg::DayW){1'b0}}, days_max};

   always_comb begin
      result.day   = '0;
      result.month = '0;
      result.year  = '0;
      priority if (fmt_err_next || pos_next != dtv_pkg::TextLen) begin
         result.status = dtv_pkg::STATUS_BAD_FMT;
      end else if (dig_err_next) begin
         result.status = dtv_pkg::STATUS_NON_DIGIT;
      end else if (month_next < dtv_pkg::AccW'(1) || month_next > dtv_pkg::AccW'(12)) begin
         result.status = dtv_pkg::STATUS_BAD_MONTH;
      end else if (day_next < dtv_pkg::AccW'(1) || day_next > month_len) begin
         result.status = dtv_pkg::STATUS_BAD_DAY;
      end else begin
         result.status = dtv_pkg::STATUS_OK;
         result.day    = day_next[dtv_pkg::DayW-1:0];
         result.month  = month_next[dtv_pkg::MonthW-1:0];
         result.year   = year_next;
      end
   end

   // The final character returns every field to its reset value.
   always_comb begin
      pos_in     = pos_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      yr_hi_in   = yr_hi_ff;
      yr_lo_in   = yr_lo_ff;
      fmt_err_in = fmt_err_ff;
      dig_err_in = dig_err_ff;
      if (step) begin
         if (last_char) begin
            pos_in     = '0;
            day_in     = '0;
            month_in   = '0;
            year_in    = '0;
            yr_hi_in   = '0;
            yr_lo_in   = '0;
            fmt_err_in = 1'b0;
            dig_err_in = 1'b0;
         end else begin
            pos_in     = pos_next;
            day_in     = day_next;
            month_in   = month_next;
            year_in    = year_next;
            yr_hi_in   = yr_hi_next;
            yr_lo_in   = yr_lo_next;
            fmt_err_in = fmt_err_next;
            dig_err_in = dig_err_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         day_ff     <= '0;
         month_ff   <= '0;
         year_ff    <= '0;
         yr_hi_ff   <= '0;
         yr_lo_ff   <= '0;
         fmt_err_ff <= 1'b0;
         dig_err_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         day_ff     <= day_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
         yr_hi_ff   <= yr_hi_in;
         yr_lo_ff   <= yr_lo_in;
         fmt_err_ff <= fmt_err_in;
         dig_err_ff <= dig_err_in;
      end
   end

endmodule

@@ bench/tb_date_text_validator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Date text validator testbench
// Streams dd/mm/yyyy texts one character per beat into the validator. The
// texts are directed corner cases first, then random dates, some of them
// corrupted or replaced by noise. A parser model in the bench predicts each
// status beat, and a monitor checks every result beat against the oldest
// prediction. The run goes through two mixes of sender and receiver stalls,
// then a phase with no random stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_date_text_validator;
   import dtv_pkg::*;

   typedef struct packed {
      logic [CharW-1:0] code;
      logic             last;
   } char_beat_type;

   localparam int WatchdogLimit = 3000;
   localparam int HoldCycles    = 120;
   localparam int DrainCycles   = 10;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [CharW-1:0]    req_char_code = '0;
   logic                req_last_char = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [StatusW-1:0]  rsp_status;
   logic [DayW-1:0]     rsp_day;
   logic [MonthW-1:0]   rsp_month;
   logic [YearW-1:0]    rsp_year;

   char_beat_type pending_chars[$];
   result_type    expected_dates[$];
   char_beat_type next_beat;
   result_type    oldest_date;

   // Text under construction before it goes to the pending queue.
   logic [CharW-1:0] text_buf [0:15];
   int               text_len;

   // Parser model state.
   logic [PosW-1:0]   char_pos   = '0;
   logic [AccW-1:0]   day_acc    = '0;
   logic [AccW-1:0]   month_acc  = '0;
   logic [YearW-1:0]  year_acc   = '0;
   logic              format_bad = 1'b0;
   logic              digit_bad  = 1'b0;

   int send_idle_pct = 24;
   int recv_idle_pct = 85;
   bit hold_wanted   = 1'b0;
   bit hold_done     = 1'b0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int mismatch_count = 0;

   date_text_validator u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_day       (rsp_day),
      .rsp_month     (rsp_month),
      .rsp_year      (rsp_year)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int days_in_month(input int month, input int year);
      bit leap_year;
      leap_year = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      case (month)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Advances the parser model by one accepted character and queues the
   // status beat that the final character produces.
   task automatic parse_date_char(input logic [CharW-1:0] c, input logic last);
      logic [PosW-1:0] p;
      int              v;
      result_type      r;
      p = char_pos;
      if (p == PosSep1 || p == PosSep2) begin
         if (c != CharSlash) format_bad = 1'b1;
      end else if (p < TextLen) begin
         if (c < CharZero || c > CharNine) begin
            digit_bad = 1'b1;
         end else begin
            v = int'(c - CharZero);
            if (p < PosSep1)
               day_acc = AccW'(day_acc * 10 + v);
            else if (p < PosSep2)
               month_acc = AccW'(month_acc * 10 + v);
            else
               year_acc = YearW'(year_acc * 10 + v);
         end
      end else begin
         format_bad = 1'b1;
      end
      if (p < PosSat) p = p + 1'b1;
      char_pos = p;

      if (last) begin
         r = '0;
         if (format_bad || p != TextLen)
            r.status = STATUS_BAD_FMT;
         else if (digit_bad)
            r.status = STATUS_NON_DIGIT;
         else if (month_acc < 1 || month_acc > 12)
            r.status = STATUS_BAD_MONTH;
         else if (day_acc < 1 || day_acc > days_in_month(month_acc, year_acc))
            r.status = STATUS_BAD_DAY;
         else begin
            r.status = STATUS_OK;
            r.day    = DayW'(day_acc);
            r.month  = MonthW'(month_acc);
            r.year   = year_acc;
         end
         expected_dates.push_back(r);
         char_pos   = '0;
         day_acc    = '0;
         month_acc  = '0;
         year_acc   = '0;
         format_bad = 1'b0;
         digit_bad  = 1'b0;
      end
   endtask

   task automatic put_char(input logic [CharW-1:0] c);
      text_buf[text_len] = c;
      text_len++;
   endtask

   task automatic put_two(input int v);
      put_char(CharZero + CharW'(v / 10));
      put_char(CharZero + CharW'(v % 10));
   endtask

   // Moves the text buffer to the pending queue, flagging its final beat.
   task automatic send_text();
      char_beat_type b;
      for (int i = 0; i < text_len; i++) begin
         b.code = text_buf[i];
         b.last = (i == text_len - 1);
         pending_chars.push_back(b);
      end
      text_len = 0;
   endtask

   task automatic send_string(input string s);
      text_len = 0;
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
      send_text();
   endtask

   task automatic send_date(input int d, input int m, input int y);
      text_len = 0;
      put_two(d);
      put_char(CharSlash);
      put_two(m);
      put_char(CharSlash);
      put_two(y / 100);
      put_two(y % 100);
      send_text();
   endtask

   // Mostly well-formed dates with random content, biased toward February
   // and century years; some get corrupted, the rest are byte noise.
   task automatic send_random_text();
      int kind, d, m, y, n;
      kind = $urandom_range(99);
      text_len = 0;
      if (kind < 85) begin
         m = ($urandom_range(9) < 8) ? $urandom_range(12, 1) : $urandom_range(99, 0);
         case ($urandom_range(3))
            0:       y = $urandom_range(9999, 0);
            1:       y = 4 * $urandom_range(2499, 0);
            2:       y = 100 * $urandom_range(99, 0);
            default: y = 400 * $urandom_range(24, 0);
         endcase
         if ($urandom_range(3) == 0) begin
            m = 2;
            d = $urandom_range(30, 27);
         end else if ($urandom_range(4) == 0) begin
            d = $urandom_range(99, 0);
         end else begin
            d = $urandom_range(31, 1);
         end
         put_two(d);
         put_char(CharSlash);
         put_two(m);
         put_char(CharSlash);
         put_two(y / 100);
         put_two(y % 100);
         if (kind >= 70) begin
            case ($urandom_range(2))
               0:       text_buf[$urandom_range(9, 0)] = CharW'($urandom_range(255, 0));
               1:       text_len = $urandom_range(9, 1);
               default: begin
                  n = $urandom_range(4, 1);
                  repeat (n) put_char(CharW'($urandom_range(255, 0)));
               end
            endcase
         end
      end else begin
         n = $urandom_range(14, 1);
         repeat (n) begin
            if ($urandom_range(1) == 0)
               put_char(CharW'($urandom_range(255, 0)));
            else
               put_char(CharW'($urandom_range(CharNine, CharSlash)));
         end
      end
      send_text();
   endtask

   task automatic wait_all_done();
      @(negedge clock);
      while (pending_chars.size() != 0 || req_valid || expected_dates.size() != 0)
         @(negedge clock);
   endtask

   // Character driver: a new beat is offered only when the current one has
   // been taken or none is up.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            parse_date_char(req_char_code, req_last_char);
         if (!req_valid || !req_stall) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = pending_chars.pop_front();
               req_valid     <= 1'b1;
               req_char_code <= next_beat.code;
               req_last_char <= next_beat.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected result, s/d/m/y %0d/%0d/%0d/%0d",
                        $time, rsp_status, rsp_day, rsp_month, rsp_year);
            end else begin
               oldest_date = expected_dates.pop_front();
               if ({rsp_status, rsp_day, rsp_month, rsp_year} !== oldest_date) begin
                  mismatch_count++;
                  $display("%0t ns: exp s/d/m/y %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           $time, oldest_date.status, oldest_date.day, oldest_date.month,
                           oldest_date.year, rsp_status, rsp_day, rsp_month, rsp_year);
               end
            end
         end
         if (hold_wanted && !hold_done) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Ends the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, WatchdogLimit);
            $display("** date_text_validator: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Leap rules, calendar extremes and year zero.
      send_date(29, 2, 2000);
      send_date(29, 2, 1900);
      send_date(29, 2, 2024);
      send_date(29, 2, 2023);
      send_date(29, 2, 0);
      send_date(31, 12, 9999);
      send_date(1, 1, 0);
      // Month and day out of range.
      send_date(0, 1, 2000);
      send_date(1, 0, 2000);
      send_date(1, 13, 2000);
      send_date(31, 4, 2001);
      send_date(99, 99, 9999);
      // Separators, length and priority of the error codes.
      send_string("01-01-2000");
      send_string("1/1/2000");
      send_string("01/01/20000");
      send_string("01/01/2000/12");
      send_string("5");
      send_string("0a-01/2000");
      send_string("0:/01/2/00");
      text_len = 0;
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CharSlash);
      put_two(1);
      put_char(CharSlash);
      put_two(20);
      put_two(0);
      send_text();
      send_string("01/01/2000");
      text_buf[0] = CharZero;
      text_buf[1] = CharZero + 8'd1;
      text_buf[2] = 8'hFF;
      text_len = 3;
      send_text();
      wait_all_done();

      repeat (19) send_random_text();
      wait_all_done();

      send_idle_pct = 85;
      recv_idle_pct = 24;
      repeat (19) send_random_text();
      wait_all_done();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_wanted   = 1'b1;
      repeat (19) send_random_text();
      wait_all_done();

      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_dates.size() == 0)
         $display("** date_text_validator: PASSED **");
      else
         $display("** date_text_validator: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
hdl/dtv_pkg.sv
hdl/dtv_parser.sv
hdl/date_text_validator.sv
bench/tb_date_text_validator.sv
